### sv/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: character codes,
// result kinds and the result record that moves between the sequencer and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

  // Default line store depth; the line holds at most depth minus one bytes
  localparam int unsigned LineDepthDef = 32;

  // Control characters
  localparam logic [7:0] ChEsc     = 8'd27;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChDel     = 8'd127;
  localparam logic [7:0] ChBs      = 8'h08;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  // Escape tracking codes
  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscSkip1 = 2'd1;
  localparam logic [1:0] EscSkip2 = 2'd2;

  // One result transaction
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### sv/terminal_line_editor.sv
// ----------------------------------------------------------------------------
// terminal_line_editor
// Serial console line discipline: edits a line from received bytes, echoes
// them and emits the finished line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   byte per transaction. Output channel (out_valid_o / out_ready_i) carries
//   kind_o, out_byte_o and last_o; last_o marks the final result of a byte.
//   The input is taken only while the sequencer is idle. A printable byte
//   is accepted and then echoed; an escape byte or a dropped byte is only
//   accepted; backspace echoes backspace, space, backspace; CR or LF echoes
//   CR and LF, then each stored byte in order, or an empty-line result.
//   The line walk reads the store one entry per cycle while the receiver
//   takes each byte, through its single registered read port, with the next
//   read issued as each byte leaves. When the receiver stalls, the output
//   register holds its result and the sequencer waits; nothing is dropped.
//   Reset clears the fill count, the escape state and the output register;
//   the line store has no reset and is never read above the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_editor #(
  parameter int unsigned LINE_DEPTH = tle_pkg::LineDepthDef,
  localparam int unsigned AW = $clog2(LINE_DEPTH)
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [1:0] kind_o,
  output logic      [7:0] out_byte_o,
  output logic            last_o
);
  import tle_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ECHO  = 3'd1;
  localparam logic [2:0] S_CR    = 3'd2;
  localparam logic [2:0] S_LF    = 3'd3;
  localparam logic [2:0] S_LINE  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;
  localparam logic [2:0] S_BS1   = 3'd6;
  localparam logic [2:0] S_BS2   = 3'd7;

  localparam logic [AW-1:0] FillMax = AW'(LINE_DEPTH - 1);

  logic [2:0]    state_q, state_d;
  logic [1:0]    esc_q, esc_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          sp_q, sp_d;
  logic [7:0]    byte_q;

  logic          in_fire;
  logic          push_valid, push_ready, push_fire;
  result_t       push_data, out_data;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          line_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign push_fire  = push_valid && push_ready;
  assign line_end   = (idx_q == AW'(fill_q - AW'(1)));

  // Decode input, build results and walk the store
  always_comb begin
    state_d    = state_q;
    esc_d      = esc_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    sp_d       = sp_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_q;
    push_valid = 1'b0;
    push_data  = '{kind: KIND_ECHO, data: 8'd0, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (esc_q == EscSkip1) begin
            esc_d = (rx_byte_i == ChBracket) ? EscSkip2 : EscNone;
          end else if (esc_q != EscNone) begin
            esc_d = EscNone;
          end else if (rx_byte_i == ChEsc) begin
            esc_d = EscSkip1;
          end else if (rx_byte_i == ChCr || rx_byte_i == ChLf) begin
            state_d = S_CR;
          end else if (rx_byte_i == ChBs || rx_byte_i == ChDel) begin
            if (fill_q != '0) begin
              fill_d  = AW'(fill_q - AW'(1));
              sp_d    = 1'b0;
              state_d = S_BS1;
            end
          end else if (fill_q < FillMax) begin
            ram_we  = 1'b1;
            fill_d  = AW'(fill_q + AW'(1));
            state_d = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, data: byte_q, last: 1'b1};
        if (push_fire) state_d = S_IDLE;
      end
      S_CR: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, data: ChCr, last: 1'b0};
        if (push_fire) state_d = S_LF;
      end
      S_LF: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, data: ChLf, last: 1'b0};
        if (push_fire) begin
          if (fill_q == '0) begin
            state_d = S_EMPTY;
          end else begin
            // Fetch the first stored byte
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_LINE;
          end
        end
      end
      S_LINE: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_LINE, data: ram_rdata, last: line_end};
        if (push_fire) begin
          if (line_end) begin
            fill_d  = '0;
            state_d = S_IDLE;
          end else begin
            // Prefetch the next byte as this one leaves
            idx_d     = AW'(idx_q + AW'(1));
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_q + AW'(1));
          end
        end
      end
      S_EMPTY: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
        if (push_fire) state_d = S_IDLE;
      end
      S_BS1: begin
        // Backspace, then space
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, data: (sp_q ? ChSpace : ChBs), last: 1'b0};
        if (push_fire) begin
          if (sp_q) state_d = S_BS2;
          else sp_d = 1'b1;
        end
      end
      S_BS2: begin
        push_valid = 1'b1;
        push_data  = '{kind: KIND_ECHO, data: ChBs, last: 1'b1};
        if (push_fire) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      esc_q   <= EscNone;
      fill_q  <= '0;
      idx_q   <= '0;
      sp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      sp_q    <= sp_d;
    end
  end

  // Hold the byte to echo
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= rx_byte_i;
    end
  end

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tle_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o     = out_data.kind;
  assign out_byte_o = out_data.data;
  assign last_o     = out_data.last;

  // Fill count stays within the line capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillMax)
    else $error("fill count beyond line capacity");

  // A pushed final result returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && push_data.last |=> state_q == S_IDLE)
    else $error("sequencer not idle after final result");

  // A line walk never reads past the stored bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LINE |-> idx_q < fill_q)
    else $error("line walk past fill count");

  // The second skip phase only follows the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_d == EscSkip2 && esc_q != EscSkip2 |-> esc_q == EscSkip1)
    else $error("bracket skip without escape");

endmodule

`default_nettype wire

### sv/tle_ram.sv
// ----------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read synchronous RAM. The read data is
// registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/tle_obuf.sv
// ----------------------------------------------------------------------------
// tle_obuf
// One-entry output register. Holds a result transaction until the receiver
// takes it and accepts a new one in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_obuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire tle_pkg::result_t push_data_i,
  output logic                  push_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output tle_pkg::result_t      out_data_o
);
  import tle_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign push_ready_o = !valid_q || out_ready_i;

  // Track occupancy
  always_comb begin
    valid_d = valid_q;
    if (push_ready_o) begin
      valid_d = push_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on push
  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

### test/terminal_line_editor_tb.sv
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// Self-checking bench for the terminal line editor. Received bytes go in
// through the valid/ready input channel. A line-editing predictor in the
// bench works out the echo and completed-line transactions that each
// accepted byte should cause. Every transaction on the output channel is
// checked field by field against the oldest pending prediction. The run has
// directed cases first: editing, the escape rules, the empty line and a full
// line store under a long receiver hold-off. Random lines and random noise
// follow, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module terminal_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  localparam int unsigned LineDepth   = LineDepthDef;
  localparam int unsigned LineAw      = $clog2(LineDepth);
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxReports  = 10;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  // Predictor state: line contents, fill count and escape tracking
  logic [7:0]  line_mem [LineDepth];
  logic [5:0]  line_len  = '0;
  logic [1:0]  esc_state = EscNone;
  result_t     console_q [$];

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  logic        hold_on      = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  result_t     want;

  terminal_line_editor #(
    .LINE_DEPTH(LineDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic result_t mk_result(input kind_e kind, input logic [7:0] data);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    return 8'($urandom_range(32, 126));
  endfunction

  // Advance the line editor by one received byte and queue what it emits
  task automatic apply_rx_byte(input logic [7:0] b, output int produced);
    result_t run [$];
    result_t r;
    int      i;
    if (esc_state == EscSkip1) begin
      esc_state = (b == ChBracket) ? EscSkip2 : EscNone;
    end else if (esc_state != EscNone) begin
      esc_state = EscNone;
    end else if (b == ChEsc) begin
      esc_state = EscSkip1;
    end else if (b == ChCr || b == ChLf) begin
      run.push_back(mk_result(KIND_ECHO, ChCr));
      run.push_back(mk_result(KIND_ECHO, ChLf));
      if (line_len == 0) begin
        run.push_back(mk_result(KIND_EMPTY, 8'h00));
      end else begin
        for (i = 0; i < int'(line_len); i++) begin
          run.push_back(mk_result(KIND_LINE, line_mem[LineAw'(i)]));
        end
      end
      line_len = '0;
    end else if (b == ChBs || b == ChDel) begin
      if (line_len != 0) begin
        line_len = line_len - 1'b1;
        run.push_back(mk_result(KIND_ECHO, ChBs));
        run.push_back(mk_result(KIND_ECHO, ChSpace));
        run.push_back(mk_result(KIND_ECHO, ChBs));
      end
    end else if (int'(line_len) < LineDepth - 1) begin
      line_mem[LineAw'(line_len)] = b;
      line_len = line_len + 1'b1;
      run.push_back(mk_result(KIND_ECHO, b));
    end
    produced = run.size();
    if (produced != 0) begin
      r = run.pop_back();
      r.last = 1'b1;
      run.push_back(r);
    end
    foreach (run[k]) console_q.push_back(run[k]);
  endtask

  // Offer one byte, hold it until the transaction completes, then predict
  task automatic send_rx(input logic [7:0] b, output int produced);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_rx_byte(b, produced);
  endtask

  task automatic flag_mismatch(input string what);
    if (mismatch_cnt < MaxReports) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // Receiver: random stalls, or a forced hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || hold_on) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (console_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected kind %0d byte %02h last %0b",
                                kind_o, out_byte_o, last_o));
      end else begin
        want = console_q.pop_front();
        if (kind_o !== want.kind || out_byte_o !== want.data || last_o !== want.last) begin
          flag_mismatch($sformatf("expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                                  want.kind, want.data, want.last,
                                  kind_o, out_byte_o, last_o));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Editing, empty line, escape rules, zero and high bytes
  task automatic test_directed();
    logic [7:0] seq [$] = '{8'h61, 8'h00, 8'hFF, ChBs, ChDel, ChBs, ChBs, ChCr,
                            8'h78, ChLf,
                            ChEsc, ChCr, ChEsc, ChBracket, 8'h41, ChEsc, ChEsc,
                            ChEsc, ChBracket, ChBs,
                            8'h80, ChCr};
    int n;
    idle_pct  = 0;
    stall_pct = 0;
    foreach (seq[k]) send_rx(seq[k], n);
  endtask

  // Start a receiver hold-off, fill the store, then overflow and flush it
  task automatic test_capacity_backpressure();
    int n;
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on <= 1'b0;
      end
      begin
        repeat (LineDepth - 1) send_rx(pick_char(), n);
        send_rx(8'hFF, n);
        send_rx(ChDel, n);
        send_rx(8'h71, n);
        send_rx(8'h7A, n);
        send_rx(ChCr, n);
      end
    join
  endtask

  // Mostly well-formed lines with edits and escapes, some raw noise
  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned count);
    int unsigned done_cnt;
    int unsigned len;
    int          n;
    logic [7:0]  b;
    idle_pct  = idle;
    stall_pct = stall;
    done_cnt  = 0;
    while (done_cnt < count) begin
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(25, 36) : $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(19))
            0, 1: b = $urandom_range(1) ? ChBs : ChDel;
            2: begin
              send_rx(ChEsc, n);
              done_cnt++;
              if ($urandom_range(1)) begin
                send_rx(ChBracket, n);
                done_cnt++;
              end
              b = 8'($urandom);
            end
            3: b = 8'($urandom);
            default: b = pick_char();
          endcase
          send_rx(b, n);
          done_cnt++;
        end
        send_rx($urandom_range(1) ? ChCr : ChLf, n);
        done_cnt++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_rx(8'($urandom), n);
          done_cnt++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_backpressure();
    test_random(0, 0, 45);
    test_random(47, 0, 45);
    test_random(0, 47, 45);
    test_random(23, 23, 45);
    in_valid_i <= 1'b0;
    while (console_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### terminal_line_editor.f
sv/tle_pkg.sv
sv/tle_ram.sv
sv/tle_obuf.sv
sv/terminal_line_editor.sv
test/terminal_line_editor_tb.sv
